// File: hdl/tpdp_pkg.sv
// ----------------------------------------------------------------------------
// tpdp_pkg
// shared types and constants of the timestamp pattern date parser
// ----------------------------------------------------------------------------
package tpdp_pkg;

  localparam int PATTERN_CHARS = 32;
  localparam int POS_W         = 6;
  localparam int CFG_IDX_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INCOMPATIBLE = 3'd1,
    ST_BAD_PATTERN  = 3'd2,
    ST_NOT_IMPL     = 3'd3,
    ST_BAD_DATE     = 3'd4
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             esc;
    logic [3:0]       cnt;
    logic [13:0]      fval;
    logic [11:0]      mask;
    logic [13:0]      year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic             wd_given;
    logic [2:0]       wd;
    status_t          err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    pos: '0, esc: 1'b0, cnt: '0, fval: '0, mask: 12'hFFF,
    year: 14'd1970, month: 4'd1, day: 5'd1, wd_given: 1'b0, wd: '0,
    err: ST_OK
  };

  // snapshot of a finished record handed to the calendar pipeline
  typedef struct packed {
    status_t     status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        wd_given;
    logic [2:0]  wd;
  } cal_req_t;

endpackage

// File: hdl/tpdp_char_step.sv
// ----------------------------------------------------------------------------
// tpdp_char_step
// next parse state for one timestamp character against the pattern
// ----------------------------------------------------------------------------
module tpdp_char_step (
  input  tpdp_pkg::parse_state_t cur,
  input  logic [7:0]             ch,
  input  logic [255:0]           pattern,
  input  logic [5:0]             pat_len,
  output tpdp_pkg::parse_state_t nxt
);
  import tpdp_pkg::*;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] SET_MONTH_LONG  = 2'd0;
  localparam logic [1:0] SET_MONTH_SHORT = 2'd1;
  localparam logic [1:0] SET_WEEKDAY     = 2'd2;

  localparam logic [71:0] MONTH_TXT [12] = '{
    "January", "February", "March", "April", "May", "June", "July",
    "August", "September", "October", "November", "December"};
  localparam logic [3:0] MONTH_LEN [12] = '{
    4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd9, 4'd7, 4'd8, 4'd8};
  localparam logic [23:0] WDAY_TXT [7] = '{
    "Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};

  function automatic logic [3:0] name_len(input logic [1:0] set, input logic [3:0] i);
    logic [3:0] r;
    r = '0;
    unique case (set)
      SET_MONTH_LONG:  r = MONTH_LEN[i];
      SET_MONTH_SHORT: r = 4'd3;
      default:         r = (i < 4'd7) ? 4'd3 : 4'd0;
    endcase
    return r;
  endfunction

  // character k of name i; caller guarantees k below the name length
  function automatic logic [7:0] name_char(input logic [1:0] set, input logic [3:0] i,
                                           input logic [3:0] k);
    logic [3:0] b;
    logic [7:0] r;
    b = '0;
    r = '0;
    unique case (set)
      SET_MONTH_LONG, SET_MONTH_SHORT: begin
        b = MONTH_LEN[i] - 4'd1 - k;
        r = MONTH_TXT[i][{b, 3'b000} +: 8];
      end
      default: begin
        b = 4'd2 - k;
        r = (i < 4'd7) ? WDAY_TXT[i[2:0]][{b[1:0], 3'b000} +: 8] : 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic parse_state_t field_done(input parse_state_t s);
    parse_state_t r;
    r = s;
    r.cnt  = '0;
    r.fval = '0;
    r.mask = 12'hFFF;
    r.esc  = 1'b0;
    r.pos  = s.pos + 6'd1;
    return r;
  endfunction

  logic [7:0]  pc0, pc1, sc;
  logic [4:0]  idx1;
  logic [5:0]  spos;
  logic [3:0]  need, dv, cnt_n, len_i, hit;
  logic        is_dig, dig_ok, hit_f;
  logic [17:0] fv_wide;
  logic [13:0] fv;
  logic [1:0]  set;
  logic [11:0] new_mask;

  assign idx1 = cur.pos[4:0] + 5'd1;
  assign pc0  = pattern[{cur.pos[4:0], 3'b000} +: 8];
  assign pc1  = pattern[{idx1, 3'b000} +: 8];

  always_comb begin
    nxt      = cur;
    sc       = cur.esc ? pc0 : pc1;
    spos     = cur.pos + 6'd1;
    need     = (sc == "Y") ? 4'd4 : 4'd2;
    is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dig_ok   = is_dig || ((sc == "e") && (cur.cnt == '0) && (ch == CH_SPACE));
    dv       = is_dig ? 4'(ch - CH_ZERO) : 4'd0;
    fv_wide  = 18'(cur.fval) * 18'd10 + 18'(dv);
    fv       = fv_wide[13:0];
    cnt_n    = cur.cnt + 4'd1;
    set      = (sc == "B") ? SET_MONTH_LONG : (sc == "b") ? SET_MONTH_SHORT : SET_WEEKDAY;
    new_mask = '0;
    hit      = '0;
    hit_f    = 1'b0;
    len_i    = '0;
    for (int i = 0; i < 12; i++) begin
      len_i       = name_len(set, 4'(i));
      new_mask[i] = cur.mask[i] && (cur.cnt < len_i) &&
                    (name_char(set, 4'(i), cur.cnt) == ch);
    end
    for (int i = 0; i < 12; i++) begin
      if (new_mask[i] && ({1'b0, name_len(set, 4'(i))} == 5'(cur.cnt) + 5'd1)) begin
        hit   = 4'(i);
        hit_f = 1'b1;
      end
    end

    if (cur.pos >= pat_len) begin
      nxt.err = cur.esc ? ST_BAD_PATTERN : ST_INCOMPATIBLE;
    end else if (!cur.esc && pc0 != CH_BSL) begin
      if (pc0 == ch) nxt.pos = spos;
      else           nxt.err = ST_INCOMPATIBLE;
    end else begin
      if (!cur.esc) begin
        nxt.esc = 1'b1;
        nxt.pos = spos;
      end
      if (nxt.pos >= pat_len) begin
        nxt.err = ST_BAD_PATTERN;
      end else begin
        unique case (sc)
          "y", "Y", "m", "d", "e": begin
            if (!dig_ok) begin
              nxt.err = ST_INCOMPATIBLE;
            end else begin
              nxt.fval = fv;
              nxt.cnt  = cnt_n;
              if (cnt_n >= need) begin
                priority if (sc == "y") begin
                  nxt.year = (fv >= 14'd69) ? fv + 14'd1900 : fv + 14'd2000;
                  nxt      = field_done(nxt);
                end else if (sc == "Y") begin
                  nxt.year = fv;
                  nxt      = field_done(nxt);
                end else if (sc == "m") begin
                  if (fv < 14'd1 || fv > 14'd12) nxt.err = ST_INCOMPATIBLE;
                  else begin
                    nxt.month = fv[3:0];
                    nxt       = field_done(nxt);
                  end
                end else begin
                  if (fv < 14'd1 || fv > 14'd31) nxt.err = ST_INCOMPATIBLE;
                  else begin
                    nxt.day = fv[4:0];
                    nxt     = field_done(nxt);
                  end
                end
              end
            end
          end
          "B", "b", "a": begin
            nxt.mask = new_mask;
            if (new_mask == '0) begin
              nxt.err = ST_INCOMPATIBLE;
            end else begin
              nxt.cnt = cnt_n;
              if (hit_f) begin
                if (set == SET_WEEKDAY) begin
                  nxt.wd_given = 1'b1;
                  nxt.wd       = hit[2:0];
                end else begin
                  nxt.month = hit + 4'd1;
                end
                nxt = field_done(nxt);
              end
            end
          end
          CH_BSL: begin
            if (ch == CH_BSL) nxt = field_done(nxt);
            else              nxt.err = ST_INCOMPATIBLE;
          end
          "p", "H", "k", "I", "l", "M", "S", "3", "6", "9", "T", "E", "L", "C",
          "N", "z", "Z", "?", "P": nxt.err = ST_NOT_IMPL;
          default: nxt.err = ST_BAD_PATTERN;
        endcase
      end
    end
  end

endmodule

// File: hdl/tpdp_calendar.sv
// ----------------------------------------------------------------------------
// tpdp_calendar
// date check, civil day count, weekday check and epoch nanoseconds
// ----------------------------------------------------------------------------
module tpdp_calendar (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  tpdp_pkg::cal_req_t     req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             status,
  output logic signed [22:0]     day_count,
  output logic signed [63:0]     epoch_ns
);
  import tpdp_pkg::*;

  // 86400e9 = 1318359375 * 2^16
  localparam logic signed [31:0] NS_MUL = 32'sd1318359375;

  typedef struct packed {
    status_t     status;
    logic [5:0]  era;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic        wd_given;
    logic [2:0]  wd;
  } stage_b_t;

  typedef struct packed {
    status_t            status;
    logic signed [23:0] days;
    logic               wd_given;
    logic [2:0]         wd;
  } stage_c_t;

  logic     a_v, b_v, c_v;
  cal_req_t a;
  stage_b_t b, b_next;
  stage_c_t c, c_next;
  logic     a_can, b_can, c_can, o_can;

  assign o_can     = !out_valid || out_ready;
  assign c_can     = !c_v || o_can;
  assign b_can     = !b_v || c_can;
  assign a_can     = !a_v || b_can;
  assign req_ready = a_can;

  // stage a: range check, era and day of year
  logic [27:0] m100;
  logic [7:0]  q100;
  logic [13:0] r100, yy;
  logic [29:0] m400;
  logic [8:0]  q400, r400y, yoe;
  logic [5:0]  era;
  logic        early, leap, bad;
  logic [4:0]  dim;
  logic [3:0]  mm;
  logic [10:0] t153;
  logic [24:0] m5;

  always_comb begin
    early = (a.month <= 4'd2);
    m100  = 28'(a.year) * 28'd10486;
    q100  = m100[27:20];
    r100  = a.year - 14'(q100) * 14'd100;
    yy    = a.year - 14'(early);
    m400  = 30'(yy) * 30'd41944;
    q400  = m400[29:21] >> 3;
    if (early && a.year == '0) begin
      era = 6'h3F;
      yoe = 9'd399;
    end else begin
      era = q400[5:0];
      yoe = 9'(yy - 14'(q400) * 14'd400);
    end
    r400y = early ? ((yoe == 9'd399) ? 9'd0 : yoe + 9'd1) : yoe;
    leap  = (a.year[1:0] == 2'b00) && (r100 != '0 || r400y == '0);
    unique case (a.month)
      4'd2:                      dim = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   dim = 5'd30;
      default:                   dim = 5'd31;
    endcase
    bad  = (a.year > 14'd9999) || (a.month < 4'd1) || (a.month > 4'd12) ||
           (a.day < 5'd1) || (a.day > dim);
    mm   = (a.month > 4'd2) ? a.month - 4'd3 : a.month + 4'd9;
    t153 = 11'(mm) * 11'd153 + 11'd2;
    m5   = 25'(t153) * 25'd13108;

    b_next.status   = (a.status == ST_OK && bad) ? ST_BAD_DATE : a.status;
    b_next.era      = era;
    b_next.yoe      = yoe;
    b_next.doy      = 9'(m5[24:16]) + 9'(a.day) - 9'd1;
    b_next.wd_given = a.wd_given;
    b_next.wd       = a.wd;
  end

  // stage b: day count
  logic [18:0] m656;
  logic [17:0] doe;
  logic signed [23:0] era_s;

  always_comb begin
    m656  = 19'(b.yoe) * 19'd656;
    doe   = 18'(b.yoe) * 18'd365 + 18'(b.yoe >> 2) - 18'(m656[18:16]) + 18'(b.doy);
    era_s = 24'(signed'(b.era));
    c_next.status   = b.status;
    c_next.days     = era_s * 24'sd146097 + signed'(24'(doe)) - 24'sd719468;
    c_next.wd_given = b.wd_given;
    c_next.wd       = b.wd;
  end

  // stage c: weekday and nanoseconds
  logic [21:0] u;
  logic [44:0] m7;
  logic [2:0]  r7, wdc;
  logic signed [55:0] prod;
  status_t     fin;

  always_comb begin
    u    = 22'(c.days + 24'sd720006);
    m7   = 45'(u) * 45'd4793491;
    r7   = 3'(u - 22'(m7[44:25]) * 22'd7);
    wdc  = (r7 >= 3'd3) ? r7 - 3'd3 : r7 + 3'd4;
    prod = c.days * NS_MUL;
    fin  = (c.status == ST_OK && c.wd_given && wdc != c.wd) ? ST_BAD_DATE : c.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_can) a_v <= req_valid;
      if (b_can) b_v <= a_v;
      if (c_can) c_v <= b_v;
      if (o_can) out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_can && req_valid) a <= req;
    if (b_can && a_v) b <= b_next;
    if (c_can && b_v) c <= c_next;
    if (o_can && c_v) begin
      status    <= fin;
      day_count <= (fin == ST_OK) ? c.days[22:0] : '0;
      epoch_ns  <= (fin == ST_OK) ? {prod[47:0], 16'h0000} : '0;
    end
  end

endmodule

// File: hdl/timestamp_pattern_date_parser.sv
// ----------------------------------------------------------------------------
// timestamp_pattern_date_parser
// matches timestamp characters against a format pattern and returns the date
// ----------------------------------------------------------------------------
// usage:
//  - the pattern is loaded through the write port (cfg_we, cfg_index,
//    cfg_data): indexes 0 to 3 hold eight pattern characters each, lowest
//    byte first, index 4 the pattern length; write only while idle
//  - input items carry one character each (ts_char); no_char marks an item
//    without a character, record_last closes the record
//  - one result item (status, day_count, epoch_ns) follows each item with
//    record_last set
//  - throughput: one item per cycle while in_ready is high; each character
//    updates the parse state in the cycle it is accepted
//  - a result is registered in order: snapshot at the edge that accepts
//    its last item, date check, day count, then weekday and nanosecond
//    multiply into the result register
//  - a stalled receiver fills the four result stages; in_ready drops only
//    once all of them hold results
//  - reset clears the pattern, the parse state and every valid flag
// ----------------------------------------------------------------------------
module timestamp_pattern_date_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ts_char,
  input  logic                no_char,
  input  logic                record_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic signed [22:0]  day_count,
  output logic signed [63:0]  epoch_ns
);
  import tpdp_pkg::*;

  // pattern registers
  logic [63:0]  pattern_chars [4];
  logic [5:0]   pattern_length;
  logic [5:0]   pat_len;
  logic [255:0] pattern_flat;

  // parse state of the record in flight
  parse_state_t pstate, pstate_next, step_nxt, eff;
  logic         in_fire;
  cal_req_t     req;
  logic         req_valid, req_ready;

  assign pat_len      = (pattern_length > 6'(PATTERN_CHARS)) ? 6'(PATTERN_CHARS)
                                                             : pattern_length;
  assign pattern_flat = {pattern_chars[3], pattern_chars[2],
                         pattern_chars[1], pattern_chars[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) pattern_chars[i] <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT0:    pattern_chars[0] <= cfg_data;
        REG_PAT1:    pattern_chars[1] <= cfg_data;
        REG_PAT2:    pattern_chars[2] <= cfg_data;
        REG_PAT3:    pattern_chars[3] <= cfg_data;
        REG_PAT_LEN: pattern_length   <= cfg_data[5:0];
        default:     ;
      endcase
    end
  end

  tpdp_char_step u_step (
    .cur     (pstate),
    .ch      (ts_char),
    .pattern (pattern_flat),
    .pat_len (pat_len),
    .nxt     (step_nxt)
  );

  assign in_ready  = req_ready;
  assign in_fire   = in_valid && in_ready;
  assign req_valid = in_fire && record_last;

  always_comb begin
    // characters after the first error are ignored
    eff = (!no_char && pstate.err == ST_OK) ? step_nxt : pstate;

    // end-of-record checks, first match wins
    priority if (eff.err != ST_OK)    req.status = eff.err;
    else if (eff.cnt != '0)           req.status = ST_INCOMPATIBLE;
    else if (eff.esc)                 req.status = ST_BAD_PATTERN;
    else if (eff.pos != pat_len)      req.status = ST_INCOMPATIBLE;
    else                              req.status = ST_OK;
    req.year     = eff.year;
    req.month    = eff.month;
    req.day      = eff.day;
    req.wd_given = eff.wd_given;
    req.wd       = eff.wd;

    pstate_next = pstate;
    if (in_fire) pstate_next = record_last ? PARSE_RESET : eff;
  end

  always_ff @(posedge clk) begin
    if (rst) pstate <= PARSE_RESET;
    else     pstate <= pstate_next;
  end

  // date arithmetic and result register
  tpdp_calendar u_cal (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .day_count (day_count),
    .epoch_ns  (epoch_ns)
  );

  // pattern position never runs past the longest pattern
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pstate.pos <= 6'(PATTERN_CHARS))
    else $error("pattern position past end of pattern store");

  // failed records carry no date
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> day_count == '0 && epoch_ns == '0)
    else $error("failed record reports a date");

  // a good date lies between years 0 and 9999
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> day_count >= -23'sd719528 &&
                                     day_count <= 23'sd2932896)
    else $error("day count out of calendar range");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BAD_DATE)
    else $error("undefined status code");

endmodule
